[hdl/gl2c_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient L2 norm clip: shared package
// Types and constants shared by the sequencer and the add/subtract unit.
// ----------------------------------------------------------------------------
package gl2c_pkg;

	localparam int ADD_W      = 64;
	localparam int SCALE_W    = 17;
	localparam int SCALE_FRAC = 16;
	localparam int THR_W      = 32;
	localparam int NORM_W     = 32;
	localparam int EPS_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_W      = 5;

	localparam logic [SCALE_W-1:0] SCALE_ONE   = 17'h10000;
	localparam logic [ADD_W-1:0]   ROUND_HALF  = 64'h0000_0000_0000_8000;
	localparam logic [CNT_W-1:0]   ROOT_LAST   = 5'd31;
	localparam logic [CNT_W-1:0]   DIV_LAST    = 5'd16;
	localparam logic [THR_W-1:0]   THR_RESET   = 32'h0001_0000;
	localparam logic [EPS_W-1:0]   EPS_RESET   = 16'h0001;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_USE_ITEM_THR = 2'd0,
		CFG_SHARED_THR   = 2'd1,
		CFG_EPSILON      = 2'd2,
		CFG_NONE         = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'b01,
		OP_SUB = 2'b10
	} addsub_op_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL  = 9'b000000010,
		S_ADD  = 9'b000000100,
		S_NEG  = 9'b000001000,
		S_ROOT = 9'b000010000,
		S_CMP  = 9'b000100000,
		S_EPS  = 9'b001000000,
		S_DIV  = 9'b010000000,
		S_EMIT = 9'b100000000
	} state_t;

endpackage

[hdl/gl2c_addsub.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient L2 norm clip: shared add/subtract unit
// One 64-bit adder with carry out; subtraction gives carry out high when a >= b.
// ----------------------------------------------------------------------------
module gl2c_addsub (
	input  logic [gl2c_pkg::ADD_W-1:0] a,
	input  logic [gl2c_pkg::ADD_W-1:0] b,
	input  gl2c_pkg::addsub_op_t       op,
	output logic [gl2c_pkg::ADD_W-1:0] sum,
	output logic                       cout
);
	import gl2c_pkg::*;

	logic [ADD_W:0]   total;
	logic [ADD_W-1:0] b_eff;
	logic             cin;

	always_comb begin
		unique case (op)
			OP_SUB: begin
				b_eff = ~b;
				cin   = 1'b1;
			end
			default: begin
				b_eff = b;
				cin   = 1'b0;
			end
		endcase
	end

	assign total = {1'b0, a} + {1'b0, b_eff} + {{ADD_W{1'b0}}, cin};
	assign sum   = total[ADD_W-1:0];
	assign cout  = total[ADD_W];

endmodule

[hdl/gradient_l2_norm_clip_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient L2 norm clip: top level
// Clips one gradient vector by its L2 norm in two passes over the elements.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid/in_ready) carry cmd, grad_value, last and
//   item_threshold. cmd 0 adds the square of the element to a saturating
//   64-bit sum; the last such item yields one status transaction with the
//   norm, the scale and the flags. cmd 1 returns the element times the scale,
//   rounded half away from zero; its last item clears the sum and its flag.
//   Configuration writes (cfg_valid/cfg_ready) are always taken; write them
//   only while the block is idle.
// Timing:
//   One item at a time; in_ready is high only in the idle state. A plain
//   accumulate item passes the multiply and add states. An apply item passes
//   multiply, add, negate for a negative element, and emit for its result.
//   The last accumulate item goes on through root and compare, then epsilon
//   and divide only when clipping, then emit for its status: 32 root steps
//   and 17 quotient steps all go through the one shared 64-bit adder.
// Reset and stalls:
//   arst_n clears the sum, flags and norm, sets the scale to 1.0 and returns
//   the configuration to its defaults. A result waits in the output register
//   while out_ready is low; the next item is accepted meanwhile and held at
//   its own result until the register frees.
// ----------------------------------------------------------------------------
module gradient_l2_norm_clip_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [gl2c_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gl2c_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic signed [VALUE_WIDTH-1:0]         grad_value,
	input  logic                                  last,
	input  logic [gl2c_pkg::THR_W-1:0]            item_threshold,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [VALUE_WIDTH-1:0]         scaled_value,
	output logic [gl2c_pkg::NORM_W-1:0]           norm_value,
	output logic [gl2c_pkg::SCALE_W-1:0]          scale_out,
	output logic                                  clipped,
	output logic                                  sum_saturated,
	output logic                                  is_status,
	output logic                                  last_out
);
	import gl2c_pkg::*;

	localparam int MAGW   = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 33;
	localparam int PROD_W = VALUE_WIDTH + SCALE_W;

	// configuration
	logic               use_item_q;
	logic [THR_W-1:0]   shared_thr_q;
	logic [EPS_W-1:0]   eps_q;

	// vector state
	logic [ADD_W-1:0]   sum_q;
	logic               ovf_q;
	logic [NORM_W-1:0]  norm_q;
	logic [SCALE_W-1:0] scale_q;
	logic               clip_q;

	// sequencer
	state_t             state_q;
	logic               cmd_q;
	logic               last_q;
	logic               neg_q;
	logic               over_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [THR_W-1:0]   thr_q;
	logic [ADD_W-1:0]   mul_q;
	logic [VALUE_WIDTH-1:0] res_q;
	logic [ADD_W-1:0]   x_q;
	logic [NORM_W-1:0]  root_q;
	logic [33:0]        rem_q;
	logic [32:0]        div_q;
	logic [SCALE_W-1:0] dsh_q;
	logic [SCALE_W-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;

	// output register
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_scaled_q;
	logic [NORM_W-1:0]      out_norm_q;
	logic [SCALE_W-1:0]     out_scale_q;
	logic                   out_clip_q;
	logic                   out_sat_q;
	logic                   out_status_q;
	logic                   out_last_q;

	logic                   in_neg;
	logic [VALUE_WIDTH-1:0] in_mag;
	logic [MAGW-1:0]        in_mag_ext;
	logic [MAGW-1:0]        mag_ext;
	logic [31:0]            mag_lo;
	logic [ADD_W-1:0]       sq_w;
	logic [PROD_W-1:0]      prod_w;
	logic [35:0]            root_shift;
	logic [35:0]            root_trial;
	logic [34:0]            div_shift;
	logic [ADD_W-1:0]       add_a;
	logic [ADD_W-1:0]       add_b;
	addsub_op_t             add_op;
	logic [ADD_W-1:0]       add_sum;
	logic                   add_cout;
	logic [ADD_W-1:0]       sum_nxt;
	logic                   in_take;
	logic                   out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	assign in_neg     = grad_value[VALUE_WIDTH-1];
	assign in_mag     = in_neg ? (~grad_value + 1'b1) : grad_value;
	assign in_mag_ext = MAGW'(in_mag);

	assign mag_ext    = MAGW'(mag_q);
	assign mag_lo     = mag_ext[31:0];
	assign sq_w       = {32'b0, mag_lo} * {32'b0, mag_lo};
	assign prod_w     = PROD_W'(mag_q) * PROD_W'(scale_q);
	assign root_shift = {rem_q, x_q[ADD_W-1:ADD_W-2]};
	assign root_trial = {2'b00, root_q, 2'b01};
	assign div_shift  = {rem_q, dsh_q[SCALE_W-1]};
	assign sum_nxt    = (over_q || add_cout) ? {ADD_W{1'b1}} : add_sum;

	always_comb begin
		add_a  = '0;
		add_b  = '0;
		add_op = OP_ADD;
		unique case (state_q)
			S_ADD: begin
				add_op = OP_ADD;
				if (!cmd_q) begin
					add_a = sum_q;
					add_b = mul_q;
				end else begin
					add_a = mul_q;
					add_b = ROUND_HALF;
				end
			end
			S_NEG: begin
				add_op = OP_SUB;
				add_b  = ADD_W'(res_q);
			end
			S_ROOT: begin
				add_op = OP_SUB;
				add_a  = ADD_W'(root_shift);
				add_b  = ADD_W'(root_trial);
			end
			S_CMP: begin
				add_op = OP_SUB;
				add_a  = ADD_W'(thr_q);
				add_b  = ADD_W'(norm_q);
			end
			S_EPS: begin
				add_op = OP_ADD;
				add_a  = ADD_W'(norm_q);
				add_b  = ADD_W'(eps_q);
			end
			S_DIV: begin
				add_op = OP_SUB;
				add_a  = ADD_W'(div_shift);
				add_b  = ADD_W'(div_q);
			end
			default: begin
				add_op = OP_ADD;
			end
		endcase
	end

	gl2c_addsub u_addsub (
		.a    (add_a),
		.b    (add_b),
		.op   (add_op),
		.sum  (add_sum),
		.cout (add_cout)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_item_q   <= 1'b0;
			shared_thr_q <= THR_RESET;
			eps_q        <= EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_USE_ITEM_THR: use_item_q   <= cfg_data[0];
				CFG_SHARED_THR:   shared_thr_q <= cfg_data[THR_W-1:0];
				CFG_EPSILON:      eps_q        <= cfg_data[EPS_W-1:0];
				default:          ;
			endcase
		end
	end

	// sequencer and vector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			norm_q  <= '0;
			scale_q <= SCALE_ONE;
			clip_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (!cmd_q) begin
						sum_q <= sum_nxt;
						if (over_q || add_cout) begin
							ovf_q <= 1'b1;
						end
						if (last_q) begin
							cnt_q   <= ROOT_LAST;
							state_q <= S_ROOT;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (neg_q) begin
						state_q <= S_NEG;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_NEG: begin
					state_q <= S_EMIT;
				end
				S_ROOT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						norm_q  <= {root_q[NORM_W-2:0], add_cout};
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (add_cout) begin
						scale_q <= SCALE_ONE;
						clip_q  <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_EPS;
					end
				end
				S_EPS: begin
					cnt_q   <= DIV_LAST;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						scale_q <= {quo_q[SCALE_W-2:0], add_cout};
						clip_q  <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						if (cmd_q && last_q) begin
							sum_q <= '0;
							ovf_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_take) begin
					cmd_q  <= cmd;
					last_q <= last;
					neg_q  <= in_neg;
					mag_q  <= in_mag;
					over_q <= |in_mag_ext[MAGW-1:32];
					thr_q  <= use_item_q ? item_threshold : shared_thr_q;
				end
			end
			S_MUL: begin
				mul_q <= cmd_q ? ADD_W'(prod_w) : sq_w;
			end
			S_ADD: begin
				res_q  <= add_sum[VALUE_WIDTH+SCALE_FRAC-1:SCALE_FRAC];
				x_q    <= sum_nxt;
				root_q <= '0;
				rem_q  <= '0;
			end
			S_NEG: begin
				res_q <= add_sum[VALUE_WIDTH-1:0];
			end
			S_ROOT: begin
				x_q    <= {x_q[ADD_W-3:0], 2'b00};
				root_q <= {root_q[NORM_W-2:0], add_cout};
				rem_q  <= add_cout ? add_sum[33:0] : root_shift[33:0];
			end
			S_EPS: begin
				div_q <= add_sum[32:0];
				rem_q <= {3'b000, thr_q[THR_W-1:1]};
				dsh_q <= {thr_q[0], {(SCALE_W-1){1'b0}}};
			end
			S_DIV: begin
				rem_q <= add_cout ? add_sum[33:0] : div_shift[33:0];
				dsh_q <= {dsh_q[SCALE_W-2:0], 1'b0};
				quo_q <= {quo_q[SCALE_W-2:0], add_cout};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_scaled_q <= cmd_q ? res_q : '0;
			out_norm_q   <= norm_q;
			out_scale_q  <= scale_q;
			out_clip_q   <= clip_q;
			out_sat_q    <= ovf_q;
			out_status_q <= !cmd_q;
			out_last_q   <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign scaled_value  = out_scaled_q;
	assign norm_value    = out_norm_q;
	assign scale_out     = out_scale_q;
	assign clipped       = out_clip_q;
	assign sum_saturated = out_sat_q;
	assign is_status     = out_status_q;
	assign last_out      = out_last_q;

endmodule

[sim/gl2c_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient L2 norm clip: verification package
// Command codes shared by the stimulus and the result checker.
// ----------------------------------------------------------------------------
package gl2c_tb_pkg;

	typedef enum logic {
		CMD_ACCUMULATE = 1'b0,
		CMD_APPLY      = 1'b1
	} clip_cmd_t;

endpackage

[sim/gl2c_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient L2 norm clip: result checker
// Watches the configuration, input and output channels, keeps its own copy of
// the sum of squares, norm, scale and flags, and compares every output
// transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module gl2c_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [gl2c_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gl2c_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             cmd,
	input  logic signed [VALUE_WIDTH-1:0]    grad_value,
	input  logic                             last,
	input  logic [gl2c_pkg::THR_W-1:0]       item_threshold,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic signed [VALUE_WIDTH-1:0]    scaled_value,
	input  logic [gl2c_pkg::NORM_W-1:0]      norm_value,
	input  logic [gl2c_pkg::SCALE_W-1:0]     scale_out,
	input  logic                             clipped,
	input  logic                             sum_saturated,
	input  logic                             is_status,
	input  logic                             last_out,
	output int                               fail_count,
	output int                               pending,
	output int                               status_seen,
	output int                               clipped_seen,
	output int                               saturated_seen,
	output int                               element_seen
);
	import gl2c_pkg::*;
	import gl2c_tb_pkg::*;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] scaled;
		logic [NORM_W-1:0]             norm;
		logic [SCALE_W-1:0]            scale;
		logic                          clip;
		logic                          saturated;
		logic                          status;
		logic                          tail;
	} clip_result_t;

	logic                  use_item_thr;
	logic [THR_W-1:0]      shared_thr;
	logic [EPS_W-1:0]      eps;
	logic [ADD_W-1:0]      sq_sum;
	logic                  sum_sat;
	logic [NORM_W-1:0]     norm_q;
	logic [SCALE_W-1:0]    scale_q;
	logic                  clip_q;
	clip_result_t          expected_q[$];
	clip_result_t          fresh;
	clip_result_t          want;
	bit                    made;

	function automatic logic [63:0] int_sqrt(input logic [63:0] radicand);
		logic [63:0] residue;
		logic [63:0] root;
		logic [63:0] probe;
		residue = radicand;
		root = '0;
		probe = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (residue >= root + probe) begin
				residue = residue - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// Advance the norm/scale state by one input transaction.
	function automatic bit predict_clip_result(input logic op, input logic [VALUE_WIDTH-1:0] value,
			input logic tail, input logic [THR_W-1:0] ithr, output clip_result_t r);
		logic                   neg;
		logic [VALUE_WIDTH-1:0] absval;
		logic [63:0]            mag;
		logic [63:0]            sq;
		logic [63:0]            thr;
		logic [63:0]            root;
		logic [63:0]            quotient;
		logic [63:0]            rounded;
		r = '0;
		neg = value[VALUE_WIDTH-1];
		absval = neg ? (~value + 1'b1) : value;
		mag = 64'(absval);
		if (op == CMD_ACCUMULATE) begin
			if (mag > 64'hFFFF_FFFF) begin
				sq_sum = '1;
				sum_sat = 1'b1;
			end else begin
				sq = mag * mag;
				if (sq_sum > ~64'd0 - sq) begin
					sq_sum = '1;
					sum_sat = 1'b1;
				end else begin
					sq_sum = sq_sum + sq;
				end
			end
			if (!tail)
				return 1'b0;
			thr = use_item_thr ? 64'(ithr) : 64'(shared_thr);
			root = int_sqrt(sq_sum);
			norm_q = root[NORM_W-1:0];
			if (root > thr) begin
				quotient = (thr << SCALE_FRAC) / (root + 64'(eps));
				scale_q = quotient[SCALE_W-1:0];
				clip_q = 1'b1;
			end else begin
				scale_q = SCALE_ONE;
				clip_q = 1'b0;
			end
			r.norm = norm_q;
			r.scale = scale_q;
			r.clip = clip_q;
			r.saturated = sum_sat;
			r.status = 1'b1;
			r.tail = 1'b1;
			return 1'b1;
		end
		rounded = (mag * 64'(scale_q) + ROUND_HALF) >> SCALE_FRAC;
		r.scaled = neg ? -rounded[VALUE_WIDTH-1:0] : rounded[VALUE_WIDTH-1:0];
		r.norm = norm_q;
		r.scale = scale_q;
		r.clip = clip_q;
		r.saturated = sum_sat;
		r.status = 1'b0;
		r.tail = tail;
		if (tail) begin
			sq_sum = '0;
			sum_sat = 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic check_field(input string fname, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_item_thr = 1'b0;
			shared_thr = THR_RESET;
			eps = EPS_RESET;
			sq_sum = '0;
			sum_sat = 1'b0;
			norm_q = '0;
			scale_q = SCALE_ONE;
			clip_q = 1'b0;
			expected_q.delete();
			fail_count = 0;
			status_seen = 0;
			clipped_seen = 0;
			saturated_seen = 0;
			element_seen = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display({"%0t ns: unexpected result, expected none, ",
						"actual scaled %0h norm %0h scale %0h status %0b"},
						$time, scaled_value, norm_value, scale_out, is_status);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("scaled_value", 64'($unsigned(want.scaled)),
						64'($unsigned(scaled_value)));
					check_field("norm_value", 64'(want.norm), 64'(norm_value));
					check_field("scale_out", 64'(want.scale), 64'(scale_out));
					check_field("clipped", 64'(want.clip), 64'(clipped));
					check_field("sum_saturated", 64'(want.saturated), 64'(sum_saturated));
					check_field("is_status", 64'(want.status), 64'(is_status));
					check_field("last_out", 64'(want.tail), 64'(last_out));
					if (want.status) begin
						status_seen++;
						clipped_seen += want.clip;
						saturated_seen += want.saturated;
					end else begin
						element_seen++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_USE_ITEM_THR: use_item_thr = cfg_data[0];
					CFG_SHARED_THR:   shared_thr = cfg_data[THR_W-1:0];
					CFG_EPSILON:      eps = cfg_data[EPS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				made = predict_clip_result(cmd, grad_value, last, item_threshold, fresh);
				if (made)
					expected_q.push_back(fresh);
			end
			pending <= expected_q.size();
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient L2 norm clip: testbench top
// Drives directed and random accumulate/apply passes through the clipper
// under several threshold and epsilon settings, with bursty input and a
// stalling receiver; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

	import gl2c_pkg::*;
	import gl2c_tb_pkg::*;

	localparam int VW             = 32;
	localparam int IDLE_GAP       = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIRECTED_ITEMS = 22;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 183;
	localparam logic signed [VW-1:0] GRAD_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] GRAD_MIN = {1'b1, {(VW-1){1'b0}}};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_USE_ITEM_THR;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   cmd = CMD_ACCUMULATE;
	logic signed [VW-1:0]   grad_value = '0;
	logic                   last = 1'b0;
	logic [THR_W-1:0]       item_threshold = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic signed [VW-1:0]   scaled_value;
	logic [NORM_W-1:0]      norm_value;
	logic [SCALE_W-1:0]     scale_out;
	logic                   clipped;
	logic                   sum_saturated;
	logic                   is_status;
	logic                   last_out;

	int                     fail_count;
	int                     pending;
	int                     status_seen;
	int                     clipped_seen;
	int                     saturated_seen;
	int                     element_seen;

	int                     n_sent = 0;
	int                     n_settings = 1;
	int                     burst_left = 0;
	int                     gap_max = 0;
	int                     stall_mode = 0;
	int                     stall_phase = 0;
	int                     stall_run = 0;
	int                     idle_cycles = 0;
	logic signed [VW-1:0]   vec[16];

	always #5 clk = ~clk;

	gradient_l2_norm_clip_top #(
		.VALUE_WIDTH(VW)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.grad_value    (grad_value),
		.last          (last),
		.item_threshold(item_threshold),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.scaled_value  (scaled_value),
		.norm_value    (norm_value),
		.scale_out     (scale_out),
		.clipped       (clipped),
		.sum_saturated (sum_saturated),
		.is_status     (is_status),
		.last_out      (last_out)
	);

	gl2c_checker #(
		.VALUE_WIDTH(VW)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.grad_value    (grad_value),
		.last          (last),
		.item_threshold(item_threshold),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.scaled_value  (scaled_value),
		.norm_value    (norm_value),
		.scale_out     (scale_out),
		.clipped       (clipped),
		.sum_saturated (sum_saturated),
		.is_status     (is_status),
		.last_out      (last_out),
		.fail_count    (fail_count),
		.pending       (pending),
		.status_seen   (status_seen),
		.clipped_seen  (clipped_seen),
		.saturated_seen(saturated_seen),
		.element_seen  (element_seen)
	);

	// Receiver: always ready, random, periodic, or long runs of stall.
	always @(posedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: begin
				stall_phase <= (stall_phase + 1) % 7;
				out_ready <= (stall_phase < 4);
			end
			default: begin
				if (stall_run == 0) begin
					stall_run <= $urandom_range(1, 40);
					out_ready <= ~out_ready;
				end else begin
					stall_run <= stall_run - 1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic signed [VW-1:0] pick_grad();
		logic [VW-1:0] mag;
		case ($urandom_range(0, 11))
			0: return GRAD_MAX;
			1: return GRAD_MIN;
			2: return '0;
			3: return '1;
			4, 5: return VW'($urandom);
			default: begin
				mag = VW'($urandom_range(0, 1 << 20));
				return $urandom_range(0, 1) ? -mag : mag;
			end
		endcase
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(0, 1 << 21);
		endcase
	endfunction

	function automatic logic [EPS_W-1:0] pick_eps();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return EPS_W'($urandom);
		endcase
	endfunction

	function automatic int pick_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
	endfunction

	task automatic send_item(input clip_cmd_t op, input logic signed [VW-1:0] value,
			input logic tail, input logic [THR_W-1:0] thr);
		int gap;
		if (gap_max > 0 && burst_left == 0) begin
			gap = $urandom_range(1, gap_max);
			burst_left = $urandom_range(1, 24);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		cmd <= op;
		grad_value <= value;
		last <= tail;
		item_threshold <= thr;
		n_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic cfg_write_one(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Unused high bits of the narrow registers carry noise.
	task automatic set_config(input logic use_item, input logic [THR_W-1:0] thr,
			input logic [EPS_W-1:0] eps);
		cfg_write_one(CFG_USE_ITEM_THR, {31'($urandom), use_item});
		cfg_write_one(CFG_SHARED_THR, thr);
		cfg_write_one(CFG_EPSILON, {16'($urandom), eps});
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic acc_pass(input int len, input bit closed, input bit hot);
		bit tail;
		for (int i = 0; i < len; i++) begin
			if (hot)
				vec[i] = $urandom_range(0, 1) ? GRAD_MIN : GRAD_MAX;
			else
				vec[i] = pick_grad();
			tail = closed && (i == len - 1);
			send_item(CMD_ACCUMULATE, vec[i], tail, tail ? pick_threshold() : THR_W'($urandom));
		end
	endtask

	task automatic apply_pass(input int len);
		for (int i = 0; i < len; i++)
			send_item(CMD_APPLY, vec[i], i == len - 1, $urandom);
	endtask

	task automatic run_random_sequence();
		int len;
		int len2;
		len = pick_len();
		case ($urandom_range(0, 19))
			0: begin
				repeat ($urandom_range(1, 3))
					send_item(CMD_APPLY, pick_grad(), 1'($urandom_range(0, 1)), $urandom);
			end
			1: begin
				len2 = pick_len();
				acc_pass(len, 1'b1, 1'b0);
				acc_pass(len2, 1'b1, 1'b0);
				apply_pass(len2);
			end
			2: begin
				acc_pass(len, 1'b0, 1'b0);
				apply_pass(len);
			end
			3: begin
				len = $urandom_range(4, 6);
				acc_pass(len, 1'b1, 1'b1);
				apply_pass(len);
			end
			default: begin
				acc_pass(len, 1'b1, 1'b0);
				apply_pass(len);
			end
		endcase
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		stall_mode <= 1;
		gap_max = 3;

		// Apply before any status: scale is still one.
		send_item(CMD_APPLY, GRAD_MAX, 1'b0, '0);
		send_item(CMD_APPLY, GRAD_MIN, 1'b1, '1);
		// Norm above the shared threshold of one.
		send_item(CMD_ACCUMULATE, 32'sh0001_0000, 1'b0, '0);
		send_item(CMD_ACCUMULATE, 32'sh0002_0000, 1'b1, '1);
		send_item(CMD_APPLY, 32'sh0001_0000, 1'b0, '0);
		send_item(CMD_APPLY, -32'sh0002_0000, 1'b0, '0);
		send_item(CMD_APPLY, GRAD_MAX, 1'b0, '0);
		send_item(CMD_APPLY, GRAD_MIN, 1'b0, '0);
		send_item(CMD_APPLY, '0, 1'b1, '0);
		// Repeated accumulate pass keeps growing the sum.
		send_item(CMD_ACCUMULATE, 32'sh0000_8000, 1'b1, '0);
		send_item(CMD_ACCUMULATE, 32'sh0000_8000, 1'b1, '0);
		send_item(CMD_APPLY, '1, 1'b1, '0);
		// Saturate the sum of squares.
		repeat (4)
			send_item(CMD_ACCUMULATE, GRAD_MIN, 1'b0, '0);
		send_item(CMD_ACCUMULATE, GRAD_MAX, 1'b1, '0);
		send_item(CMD_APPLY, 32'sh0000_0001, 1'b1, '0);
		// Per-item threshold at both extremes.
		wait_idle();
		set_config(1'b1, THR_RESET, EPS_RESET);
		send_item(CMD_ACCUMULATE, 32'sh0003_0000, 1'b1, '0);
		send_item(CMD_APPLY, GRAD_MAX, 1'b1, '1);
		send_item(CMD_ACCUMULATE, -32'sh0003_0000, 1'b1, '1);
		send_item(CMD_APPLY, GRAD_MIN, 1'b1, '0);

		for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
			wait_idle();
			case (phase)
				1: set_config(1'b0, '0, '0);
				2: set_config(1'b0, '1, '1);
				3: begin
					cfg_write_one(CFG_NONE, $urandom);
					set_config(1'b1, $urandom, '0);
				end
				default: set_config(1'($urandom_range(0, 1)), pick_threshold(), pick_eps());
			endcase
			if (phase == 1) begin
				gap_max = 0;
				stall_mode <= 0;
			end else begin
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
				stall_mode <= $urandom_range(0, 3);
			end
			while (n_sent < DIRECTED_ITEMS + phase * PHASE_ITEMS)
				run_random_sequence();
		end

		wait_idle();
		$display("Sent %0d input transactions over %0d register settings.", n_sent, n_settings);
		$display("Checked %0d status results (%0d clipped, %0d saturated) and %0d scaled elements.",
			status_seen, clipped_seen, saturated_seen, element_seen);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/gl2c_pkg.sv
hdl/gl2c_addsub.sv
hdl/gradient_l2_norm_clip_top.sv
sim/gl2c_tb_pkg.sv
sim/gl2c_checker.sv
sim/testbench.sv
